@@ rtl/tptz_pkg.sv @@
// Package for the two-pole two-zero controller: field widths, register
// indexes, reset values and the structs passed between the modules.
// No dependencies.
`default_nettype none

package tptz_pkg;

  localparam int SAMPLE_W       = 12;
  localparam int ERR_W          = SAMPLE_W + 1;
  localparam int DRIVE_W        = 16;
  localparam int COEF_W         = 24;
  localparam int COEF_FRAC_BITS = 16;

  // Widest product is drive times coefficient; five of them need three more bits.
  localparam int PROD_W = DRIVE_W + COEF_W;
  localparam int SUM_W  = PROD_W + 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_FLOOR = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_FLOOR   = 3'd7;

  localparam logic [COEF_W-1:0]  RST_COEF_B0     = 24'h000000;
  localparam logic [COEF_W-1:0]  RST_COEF_B1     = 24'h000000;
  localparam logic [COEF_W-1:0]  RST_COEF_B2     = 24'h000000;
  localparam logic [COEF_W-1:0]  RST_COEF_A1     = 24'h010000;
  localparam logic [COEF_W-1:0]  RST_COEF_A2     = 24'h000000;
  localparam logic [DRIVE_W-1:0] RST_DRIVE_MAX   = 16'h7FFF;
  localparam logic [DRIVE_W-1:0] RST_INTEG_FLOOR = 16'h8000;
  localparam logic [DRIVE_W-1:0] RST_OUT_FLOOR   = 16'h8000;

  // All members hold two's complement values.
  typedef struct packed {
    logic [COEF_W-1:0]  coef_b0;
    logic [COEF_W-1:0]  coef_b1;
    logic [COEF_W-1:0]  coef_b2;
    logic [COEF_W-1:0]  coef_a1;
    logic [COEF_W-1:0]  coef_a2;
    logic [DRIVE_W-1:0] drive_max;
    logic [DRIVE_W-1:0] integ_floor;
    logic [DRIVE_W-1:0] out_floor;
  } cfg_t;

  typedef struct packed {
    logic [ERR_W-1:0]   err_prev1;
    logic [ERR_W-1:0]   err_prev2;
    logic [DRIVE_W-1:0] drive_prev1;
    logic [DRIVE_W-1:0] drive_prev2;
  } hist_t;

  typedef struct packed {
    logic [ERR_W-1:0]   err;
    logic [DRIVE_W-1:0] drive;
    logic [DRIVE_W-1:0] emit;
  } calc_res_t;

endpackage

`default_nettype wire

@@ rtl/tptz_cfg_regs.sv @@
// Configuration register file of the two-pole two-zero controller.
// Depends on tptz_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module tptz_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [tptz_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tptz_pkg::CFG_DATA_W-1:0] cfg_data,
  output tptz_pkg::cfg_t                      cfg
);
  import tptz_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_b0     <= RST_COEF_B0;
      cfg.coef_b1     <= RST_COEF_B1;
      cfg.coef_b2     <= RST_COEF_B2;
      cfg.coef_a1     <= RST_COEF_A1;
      cfg.coef_a2     <= RST_COEF_A2;
      cfg.drive_max   <= RST_DRIVE_MAX;
      cfg.integ_floor <= RST_INTEG_FLOOR;
      cfg.out_floor   <= RST_OUT_FLOOR;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COEF_B0:     cfg.coef_b0     <= cfg_data[COEF_W-1:0];
        REG_COEF_B1:     cfg.coef_b1     <= cfg_data[COEF_W-1:0];
        REG_COEF_B2:     cfg.coef_b2     <= cfg_data[COEF_W-1:0];
        REG_COEF_A1:     cfg.coef_a1     <= cfg_data[COEF_W-1:0];
        REG_COEF_A2:     cfg.coef_a2     <= cfg_data[COEF_W-1:0];
        REG_DRIVE_MAX:   cfg.drive_max   <= cfg_data[DRIVE_W-1:0];
        REG_INTEG_FLOOR: cfg.integ_floor <= cfg_data[DRIVE_W-1:0];
        REG_OUT_FLOOR:   cfg.out_floor   <= cfg_data[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/tptz_calc.sv @@
// Arithmetic of one controller step: error, five products, sum, floor
// shift and the three clamps. Purely combinational; depends on tptz_pkg.
`default_nettype none

module tptz_calc (
  input  wire tptz_pkg::cfg_t               cfg,
  input  wire tptz_pkg::hist_t              hist,
  input  wire logic [tptz_pkg::SAMPLE_W-1:0] reference,
  input  wire logic [tptz_pkg::SAMPLE_W-1:0] feedback,
  output tptz_pkg::calc_res_t               res
);
  import tptz_pkg::*;

  localparam int EP_W = ERR_W + COEF_W;
  localparam int SH_W = SUM_W - COEF_FRAC_BITS;

  logic        [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   err_s, e1, e2;
  logic signed [DRIVE_W-1:0] d1, d2, mx, fl, of, drive_s;
  logic signed [COEF_W-1:0]  b0, b1, b2, a1, a2;
  logic signed [EP_W-1:0]    pe0, pe1, pe2;
  logic signed [PROD_W-1:0]  pd1, pd2;
  logic signed [SUM_W-1:0]   acc;
  logic signed [SH_W-1:0]    sh, hi, lo;

  // Both samples are unsigned, so the 13-bit difference never wraps.
  assign err   = {1'b0, reference} - {1'b0, feedback};
  assign err_s = $signed(err);
  assign e1    = $signed(hist.err_prev1);
  assign e2    = $signed(hist.err_prev2);
  assign d1    = $signed(hist.drive_prev1);
  assign d2    = $signed(hist.drive_prev2);
  assign b0    = $signed(cfg.coef_b0);
  assign b1    = $signed(cfg.coef_b1);
  assign b2    = $signed(cfg.coef_b2);
  assign a1    = $signed(cfg.coef_a1);
  assign a2    = $signed(cfg.coef_a2);
  assign mx    = $signed(cfg.drive_max);
  assign fl    = $signed(cfg.integ_floor);
  assign of    = $signed(cfg.out_floor);

  assign pe0 = err_s * b0;
  assign pe1 = e1 * b1;
  assign pe2 = e2 * b2;
  assign pd1 = d1 * a1;
  assign pd2 = d2 * a2;

  assign acc = SUM_W'(pe0) + SUM_W'(pe1) + SUM_W'(pe2) + SUM_W'(pd1) + SUM_W'(pd2);

  // Dropping the fraction bits of a two's complement value rounds down.
  assign sh = $signed(acc[SUM_W-1:COEF_FRAC_BITS]);

  // The floor is applied last, so it wins when it sits above the maximum.
  assign hi = (sh > SH_W'(mx)) ? SH_W'(mx) : sh;
  assign lo = (hi < SH_W'(fl)) ? SH_W'(fl) : hi;

  assign drive_s = $signed(lo[DRIVE_W-1:0]);

  assign res.err   = err;
  assign res.drive = lo[DRIVE_W-1:0];
  assign res.emit  = (drive_s < of) ? cfg.out_floor : lo[DRIVE_W-1:0];

endmodule

`default_nettype wire

@@ rtl/two_pole_two_zero_controller.sv @@
// Top level of the two-pole two-zero controller: handshake, input register,
// history registers and result register. Uses tptz_pkg, tptz_cfg_regs, tptz_calc.
`default_nettype none

//  Channel   Signals                                   Direction  Notes
//  input     in_valid, in_stall, reference, feedback   in (stall out)  one sample pair per item
//  output    out_valid, out_stall, drive_out           out (stall in)  one drive per item
//  config    cfg_write, cfg_index, cfg_data            in         plain write, no read-back
//
// An accepted item sits in the input register until the result register can
// take it; its drive is then computed and loaded into the result register,
// where it is offered on drive_out. One item is taken every cycle while no
// output stall holds both registers full: the only loop is history -> five
// products -> sum -> clamps -> history, combinational between the history
// registers. Reset clears the history, valid flags and configuration
// registers to their defaults. A stall on the output holds the result and,
// only when the input register is also full, raises in_stall.

module two_pole_two_zero_controller (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [tptz_pkg::SAMPLE_W-1:0]   reference,
  input  wire logic [tptz_pkg::SAMPLE_W-1:0]   feedback,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [tptz_pkg::DRIVE_W-1:0]    drive_out,
  input  wire logic                           cfg_write,
  input  wire logic [tptz_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tptz_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tptz_pkg::*;

  cfg_t      cfg;
  hist_t     hist;
  calc_res_t res;

  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_reference;
  logic [SAMPLE_W-1:0] s1_feedback;
  logic                advance;
  logic                load_out;

  tptz_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tptz_calc u_calc (
    .cfg       (cfg),
    .hist      (hist),
    .reference (s1_reference),
    .feedback  (s1_feedback),
    .res       (res)
  );

  // The result register can take a new value when it is empty or is being read.
  assign advance  = !out_valid || !out_stall;
  assign load_out = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_reference <= reference;
      s1_feedback  <= feedback;
    end
  end

  // History moves exactly when an item's drive is committed to the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (load_out) begin
      hist.err_prev2   <= hist.err_prev1;
      hist.err_prev1   <= res.err;
      hist.drive_prev2 <= hist.drive_prev1;
      hist.drive_prev1 <= res.drive;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      drive_out <= res.emit;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled while a stage had room");

  a_load_gives_result: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("computed item did not reach the result register");

  a_history_shift: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (hist.drive_prev2 == $past(hist.drive_prev1)) &&
                 (hist.err_prev2 == $past(hist.err_prev1)))
    else $error("history did not shift with the item");

  a_stored_above_floor: assert property (@(posedge clk) disable iff (rst)
    load_out |=> ($signed(hist.drive_prev1) >= $signed($past(cfg.integ_floor))))
    else $error("stored drive below the integrator floor");

  a_out_above_floor: assert property (@(posedge clk) disable iff (rst)
    load_out |=> ($signed(drive_out) >= $signed($past(cfg.out_floor))))
    else $error("emitted drive below the output floor");

endmodule

`default_nettype wire

@@ sim/tptz_checker.sv @@
// Checker for the two-pole two-zero controller: watches the input, output and
// register write ports, predicts each drive and compares it with the block.
// Depends on tptz_pkg.
module tptz_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [tptz_pkg::SAMPLE_W-1:0]   reference,
  input  logic [tptz_pkg::SAMPLE_W-1:0]   feedback,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [tptz_pkg::DRIVE_W-1:0]    drive_out,
  input  logic                            cfg_write,
  input  logic [tptz_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tptz_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatch_count,
  output int                              results_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import tptz_pkg::*;

  cfg_t               gains;
  hist_t              past;
  logic [DRIVE_W-1:0] drive_due_q[$];
  int                 fails = 0;

  // One controller step: error, five products, floor shift, the two clamps
  // that set the stored drive, then the output floor on the emitted value.
  function automatic calc_res_t compensate(cfg_t c, hist_t h,
                                           logic [SAMPLE_W-1:0] r,
                                           logic [SAMPLE_W-1:0] f);
    longint    e;
    longint    acc;
    longint    d;
    calc_res_t res;
    e   = longint'(r) - longint'(f);
    acc = e * longint'($signed(c.coef_b0))
        + longint'($signed(h.err_prev1)) * longint'($signed(c.coef_b1))
        + longint'($signed(h.err_prev2)) * longint'($signed(c.coef_b2))
        + longint'($signed(h.drive_prev1)) * longint'($signed(c.coef_a1))
        + longint'($signed(h.drive_prev2)) * longint'($signed(c.coef_a2));
    d = acc >>> COEF_FRAC_BITS;
    if (d > longint'($signed(c.drive_max))) d = longint'($signed(c.drive_max));
    if (d < longint'($signed(c.integ_floor))) d = longint'($signed(c.integ_floor));
    res.err   = e[ERR_W-1:0];
    res.drive = d[DRIVE_W-1:0];
    if (d < longint'($signed(c.out_floor))) d = longint'($signed(c.out_floor));
    res.emit  = d[DRIVE_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    calc_res_t          res;
    logic [DRIVE_W-1:0] want;
    if (rst) begin
      gains = '{coef_b0: RST_COEF_B0, coef_b1: RST_COEF_B1, coef_b2: RST_COEF_B2,
                coef_a1: RST_COEF_A1, coef_a2: RST_COEF_A2,
                drive_max: RST_DRIVE_MAX, integ_floor: RST_INTEG_FLOOR,
                out_floor: RST_OUT_FLOOR};
      past = '0;
      drive_due_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_COEF_B0:     gains.coef_b0     = cfg_data[COEF_W-1:0];
          REG_COEF_B1:     gains.coef_b1     = cfg_data[COEF_W-1:0];
          REG_COEF_B2:     gains.coef_b2     = cfg_data[COEF_W-1:0];
          REG_COEF_A1:     gains.coef_a1     = cfg_data[COEF_W-1:0];
          REG_COEF_A2:     gains.coef_a2     = cfg_data[COEF_W-1:0];
          REG_DRIVE_MAX:   gains.drive_max   = cfg_data[DRIVE_W-1:0];
          REG_INTEG_FLOOR: gains.integ_floor = cfg_data[DRIVE_W-1:0];
          REG_OUT_FLOOR:   gains.out_floor   = cfg_data[DRIVE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (drive_due_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: drive_out %0d arrived with no item outstanding",
                     $time, $signed(drive_out));
        end else begin
          want = drive_due_q.pop_front();
          if (drive_out !== want) begin
            fails++;
            if (fails <= 10)
              $display("%0t: drive_out expected %0d, got %0d",
                       $time, $signed(want), $signed(drive_out));
          end
        end
      end
      if (in_valid && !in_stall) begin
        res = compensate(gains, past, reference, feedback);
        past.err_prev2   = past.err_prev1;
        past.err_prev1   = res.err;
        past.drive_prev2 = past.drive_prev1;
        past.drive_prev1 = res.drive;
        drive_due_q.push_back(res.emit);
      end
    end
    mismatch_count <= fails;
    results_due    <= drive_due_q.size();
  end
endmodule

@@ sim/tb_top.sv @@
// Top of the controller testbench: clock, reset, register setup, sample
// stimulus and the verdict. Depends on tptz_pkg, tptz_checker and the
// two_pole_two_zero_controller RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tptz_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   reference;
  logic [SAMPLE_W-1:0]   feedback;
  logic                  out_valid;
  logic                  out_stall;
  logic [DRIVE_W-1:0]    drive_out;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatch_count;
  int                    results_due;

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int idle_pct;
  int stall_pct;

  two_pole_two_zero_controller uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .reference (reference),
    .feedback  (feedback),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive_out (drive_out),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tptz_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .reference      (reference),
    .feedback       (feedback),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive_out      (drive_out),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  // 20 ns clock period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // The receiver stalls at random, drawn fresh on every edge. A stall rate of
  // zero gives the long stretch in which results drain without back-pressure.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Safety net: the slowest legal run, roughly 800 items plus register
  // writes, is far below this.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Offer one sample pair. The sender may idle first; once valid is raised the
  // payload is held until the block accepts it (valid high, stall low at an
  // edge). The task returns in the time step of that edge, so the caller can
  // drive the next item or lower valid with a single assignment.
  task automatic send_item(input int r, input int f);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    reference <= r[SAMPLE_W-1:0];
    feedback  <= f[SAMPLE_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted drive has come out. The first
  // edge lets the checker's count catch up with the last accepted item.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // Register write: drives the write enable high with index and data, then waits
  // for an edge. The enable is left high so back-to-back writes need only one assignment per edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // Write all eight registers. Only called while the block is idle.
  task automatic load_settings(input int b0, input int b1, input int b2,
                               input int a1, input int a2, input int dmax,
                               input int ifloor, input int ofloor);
    write_reg(REG_COEF_B0, b0);
    write_reg(REG_COEF_B1, b1);
    write_reg(REG_COEF_B2, b2);
    write_reg(REG_COEF_A1, a1);
    write_reg(REG_COEF_A2, a2);
    write_reg(REG_DRIVE_MAX, dmax);
    write_reg(REG_INTEG_FLOOR, ifloor);
    write_reg(REG_OUT_FLOOR, ofloor);
    cfg_write <= 1'b0;
  endtask

  // Random settings in three flavors. Tuned settings keep the loop near a
  // usable gain so the drive moves between the clamps instead of pinning at
  // one of them; full-range coefficients hit both clamps hard; loose limits
  // give inverted or narrow clamp windows and output floors above the drive.
  task automatic pick_settings(input int flavor);
    int b0, b1, b2, a1, a2, dmax, ifloor, ofloor;
    b0     = int'($urandom_range(0, 262144)) - 131072;
    b1     = int'($urandom_range(0, 262144)) - 131072;
    b2     = int'($urandom_range(0, 65536)) - 32768;
    a1     = 65536 - int'($urandom_range(0, 32768));
    a2     = int'($urandom_range(0, 16384)) - 8192;
    dmax   = int'($urandom_range(1000, 32767));
    ifloor = -int'($urandom_range(1000, 32768));
    ofloor = ($urandom_range(0, 1) == 0) ? -32768 : ifloor + int'($urandom_range(0, 2000));
    case (flavor)
      1: begin
        b0     = int'($urandom);
        b1     = int'($urandom);
        b2     = int'($urandom);
        a1     = int'($urandom);
        a2     = int'($urandom);
        dmax   = 32767;
        ifloor = -32768;
        ofloor = -32768;
      end
      2: begin
        dmax   = int'($urandom_range(0, 65535)) - 32768;
        ifloor = int'($urandom_range(0, 65535)) - 32768;
        ofloor = int'($urandom_range(0, 65535)) - 32768;
      end
      default: ;
    endcase
    load_settings(b0, b1, b2, a1, a2, dmax, ifloor, ofloor);
  endtask

  initial begin
    int setpoint;
    int fb;

    // Every input known from time zero; reset held high, then released.
    rst       = 1'b1;
    in_valid  = 1'b0;
    reference = '0;
    feedback  = '0;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_pct  = 30;
    stall_pct = 30;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a pure integrator with zero error gain, so the drive
    // must stay at zero whatever the samples are.
    send_item(4095, 0);
    send_item(0, 4095);
    send_item(1234, 1234);

    // PI-like settings, samples at their extremes in both directions.
    drain();
    load_settings(65536, -32768, 0, 65536, 0, 32767, -32768, -32768);
    send_item(0, 0);
    send_item(4095, 0);
    send_item(0, 4095);
    send_item(4095, 4095);
    send_item(2048, 2047);
    send_item(2047, 2048);

    // Integrator floor above the maximum: the floor clamp is applied last and
    // decides the stored drive.
    drain();
    load_settings(65536, 0, 0, 0, 0, -100, 100, -32768);
    send_item(4095, 0);
    send_item(0, 4095);

    // Tiny gain with negative errors: floor rounding turns each small negative
    // sum into -1, and the integrator walks down one step per item. The output
    // floor holds the emitted value at -2 while the history keeps going lower.
    drain();
    load_settings(1, 0, 0, 65536, 0, 32767, -32768, -2);
    send_item(0, 5);
    send_item(0, 4095);
    send_item(0, 1);
    send_item(0, 4095);

    // Coefficients at the ends of their range: both clamps are hit in turn.
    drain();
    load_settings(8388607, -8388608, 8388607, -8388608, 8388607, 32767, -32768, -32768);
    send_item(4095, 0);
    send_item(0, 4095);
    send_item(4095, 0);
    send_item(0, 0);

    // Random phases of 125 items each, with fresh settings before every phase.
    // Most items track a setpoint with feedback close to it, the way a loop
    // runs; the rest are arbitrary sample pairs. Phase 3 runs with neither side
    // idling, and phase 1 stops halfway until all results are back.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      pick_settings(ph % 3);
      idle_pct  = (ph == 3) ? 0 : 30;
      stall_pct = (ph == 3) ? 0 : 30;
      setpoint  = int'($urandom_range(0, 4095));
      for (int n = 0; n < 125; n++) begin
        if (ph == 1 && n == 60) drain();
        if ($urandom_range(0, 99) < 30) begin
          send_item(int'($urandom_range(0, 4095)), int'($urandom_range(0, 4095)));
        end else begin
          if ($urandom_range(0, 49) == 0) setpoint = int'($urandom_range(0, 4095));
          fb = setpoint + int'($urandom_range(0, 600)) - 300;
          if (fb < 0) fb = 0;
          if (fb > 4095) fb = 4095;
          send_item(setpoint, fb);
        end
      end
    end

    // Wait out the last results and let the input and result registers settle, then judge.
    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
